/* sv/dtq_pkg.sv */
// ----------------------------------------------------------------------------
// dtq_pkg
// shared types and constants for the rotation matrix to quaternion converter
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int ELEM_W = 16;            // matrix element and quaternion part width
    localparam int NUM_W  = ELEM_W + 1;    // element sum or difference
    localparam int ARG_W  = 32;            // square-root argument width
    localparam int QW     = NUM_W;         // quotient bits kept by the divider

    // output slot filled by the half root
    localparam logic [1:0] SLOT_SCALAR = 2'd0;
    localparam logic [1:0] SLOT_X      = 2'd1;
    localparam logic [1:0] SLOT_Y      = 2'd2;
    localparam logic [1:0] SLOT_Z      = 2'd3;

    typedef struct packed {
        logic signed [ELEM_W-1:0] row0_col0;
        logic signed [ELEM_W-1:0] row0_col1;
        logic signed [ELEM_W-1:0] row0_col2;
        logic signed [ELEM_W-1:0] row1_col0;
        logic signed [ELEM_W-1:0] row1_col1;
        logic signed [ELEM_W-1:0] row1_col2;
        logic signed [ELEM_W-1:0] row2_col0;
        logic signed [ELEM_W-1:0] row2_col1;
        logic signed [ELEM_W-1:0] row2_col2;
    } t_matrix;

    typedef struct packed {
        logic signed [ELEM_W-1:0] quat_scalar;
        logic signed [ELEM_W-1:0] quat_x;
        logic signed [ELEM_W-1:0] quat_y;
        logic signed [ELEM_W-1:0] quat_z;
        logic                     bad_matrix;
    } t_quat;

    // classified work for the back end
    typedef struct packed {
        logic [ARG_W-1:0]            arg;        // square-root argument, positive unless bad
        logic [1:0]                  half_slot;  // slot taking root / 2
        logic [2:0][NUM_W-1:0]       num;        // numerators for remaining slots, ascending
        logic                        bad;
    } t_job;

endpackage

/* sv/dtq_front.sv */
// ----------------------------------------------------------------------------
// dtq_front
// takes a matrix, picks the branch and pivot, forms argument and numerators
// ----------------------------------------------------------------------------
module dtq_front import dtq_pkg::*; #(
    parameter int FRACTION_BITS = 14
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_matrix i_matrix,
    input  logic    i_q_full,
    output logic    busy,
    output logic    o_valid,
    output t_job    o_job
);

    localparam int SW = ARG_W + 2;
    localparam logic signed [SW-1:0] ONE = SW'(64'd1 << FRACTION_BITS);

    logic             r_valid, n_valid;
    t_job             r_job;
    t_job             job;
    logic signed [17:0] tr;
    logic [1:0]         piv;
    logic signed [SW-1:0] parg, arg;
    logic               pos_tr;
    logic signed [NUM_W-1:0] d21_12, d02_20, d10_01, s01_10, s20_02, s12_21;

    always_comb begin
        tr = 18'(i_matrix.row0_col0) + 18'(i_matrix.row1_col1) + 18'(i_matrix.row2_col2);
        pos_tr = (tr > 18'sd0);
        piv = 2'd0;
        if (i_matrix.row1_col1 > i_matrix.row0_col0) begin
            piv = 2'd1;
        end
        if (piv == 2'd1) begin
            if (i_matrix.row2_col2 > i_matrix.row1_col1) begin
                piv = 2'd2;
            end
        end else begin
            if (i_matrix.row2_col2 > i_matrix.row0_col0) begin
                piv = 2'd2;
            end
        end
        case (piv)
            2'd0: parg = SW'(i_matrix.row0_col0) - SW'(i_matrix.row1_col1)
                       - SW'(i_matrix.row2_col2) + ONE;
            2'd1: parg = SW'(i_matrix.row1_col1) - SW'(i_matrix.row2_col2)
                       - SW'(i_matrix.row0_col0) + ONE;
            default: parg = SW'(i_matrix.row2_col2) - SW'(i_matrix.row0_col0)
                          - SW'(i_matrix.row1_col1) + ONE;
        endcase
        arg = pos_tr ? (SW'(tr) + ONE) : parg;

        d21_12 = NUM_W'(i_matrix.row2_col1) - NUM_W'(i_matrix.row1_col2);
        d02_20 = NUM_W'(i_matrix.row0_col2) - NUM_W'(i_matrix.row2_col0);
        d10_01 = NUM_W'(i_matrix.row1_col0) - NUM_W'(i_matrix.row0_col1);
        s01_10 = NUM_W'(i_matrix.row0_col1) + NUM_W'(i_matrix.row1_col0);
        s20_02 = NUM_W'(i_matrix.row2_col0) + NUM_W'(i_matrix.row0_col2);
        s12_21 = NUM_W'(i_matrix.row1_col2) + NUM_W'(i_matrix.row2_col1);

        job.arg = arg[ARG_W-1:0];
        job.bad = !pos_tr && (parg <= SW'(0));
        if (pos_tr) begin
            job.half_slot = SLOT_SCALAR;
        end else begin
            case (piv)
                2'd0:    job.half_slot = SLOT_X;
                2'd1:    job.half_slot = SLOT_Y;
                default: job.half_slot = SLOT_Z;
            endcase
        end
        case (job.half_slot)
            SLOT_SCALAR: job.num = {d10_01, d02_20, d21_12};
            SLOT_X:      job.num = {s20_02, s01_10, d21_12};
            SLOT_Y:      job.num = {s12_21, s01_10, d02_20};
            default:     job.num = {s12_21, s20_02, d10_01};
        endcase
    end

    assign busy    = r_valid && i_q_full;
    assign o_valid = r_valid;
    assign o_job   = r_job;

    always_comb begin
        n_valid = r_valid;
        if (start && !busy) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_q_full) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_job <= job;
        end
    end

endmodule

/* sv/dtq_queue.sv */
// ----------------------------------------------------------------------------
// dtq_queue
// two-entry queue between classification and the arithmetic pipeline
// ----------------------------------------------------------------------------
module dtq_queue import dtq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_job       i_job,
    output logic       o_full,
    output logic       o_valid,
    output t_job       o_job,
    output logic [1:0] o_count
);

    t_job       r_mem [0:1];
    logic       r_wr, r_rd;
    logic [1:0] r_count, n_count;
    logic       push, pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd];
    assign o_count = r_count;
    assign push    = i_push && !o_full;
    assign pop     = o_valid;   // back end never stalls

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

/* sv/dtq_back.sv */
// ----------------------------------------------------------------------------
// dtq_back
// pipelined square root, three pipelined dividers and result assembly
// ----------------------------------------------------------------------------
module dtq_back import dtq_pkg::*; #(
    parameter int FRACTION_BITS = 14
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_job  i_job,
    output logic  o_done,
    output t_quat o_quat
);

    localparam int AW  = (FRACTION_BITS >= 17) ? FRACTION_BITS + 1 : 18;
    localparam int XW0 = AW + FRACTION_BITS;
    localparam int RW  = (XW0 + 1) / 2;
    localparam int XW  = 2 * RW;
    localparam int CW  = RW + FRACTION_BITS + 20;
    localparam int DS  = QW + 1;

    // square root pipeline, one result bit per stage
    logic [RW+1:0] r_rem  [0:RW];
    logic [RW-1:0] r_root [0:RW];
    logic [XW-1:0] r_x    [0:RW];
    t_job          r_sjob [0:RW];
    logic          r_sv   [0:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else begin
            r_sv[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_x[0]    <= XW'(i_job.arg[AW-1:0]) << FRACTION_BITS;
        r_sjob[0] <= i_job;
    end

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        logic [RW+1:0] rem2, trial;
        logic          ge;
        assign rem2  = {r_rem[k][RW-1:0], r_x[k][XW-1 -: 2]};
        assign trial = {r_root[k], 2'b01};
        assign ge    = (rem2 >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else begin
                r_sv[k+1] <= r_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= ge ? (rem2 - trial) : rem2;
            r_root[k+1] <= {r_root[k][RW-2:0], ge};
            r_x[k+1]    <= r_x[k] << 2;
            r_sjob[k+1] <= r_sjob[k];
        end
    end

    // divider pipelines: overflow check, then one quotient bit per stage
    logic [CW-1:0] r_drem [0:2][0:DS];
    logic [QW-1:0] r_q    [0:2][0:DS];
    logic          r_ovf  [0:2][0:DS];
    logic          r_neg  [0:2][0:DS];
    logic [CW-1:0] r_dd   [0:DS];
    logic [RW-2:0] r_half [0:DS];
    logic [1:0]    r_hs   [0:DS];
    logic          r_bad  [0:DS];
    logic          r_dv   [0:DS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= r_sv[RW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dd[0]   <= CW'({r_root[RW], 1'b0});
        r_half[0] <= r_root[RW][RW-1:1];
        r_hs[0]   <= r_sjob[RW].half_slot;
        r_bad[0]  <= r_sjob[RW].bad;
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic signed [NUM_W-1:0] num;
        logic [NUM_W-1:0]        mag;
        assign num = r_sjob[RW].num[l];
        assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

        always_ff @(posedge i_clk) begin
            r_drem[l][0] <= (CW'(mag) << FRACTION_BITS) + CW'(r_root[RW]);
            r_q[l][0]    <= '0;
            r_ovf[l][0]  <= 1'b0;
            r_neg[l][0]  <= num[NUM_W-1];
        end

        for (genvar k = 0; k < DS; k++) begin : g_step
            if (k == 0) begin : g_ovf
                always_ff @(posedge i_clk) begin
                    r_drem[l][k+1] <= r_drem[l][k];
                    r_q[l][k+1]    <= r_q[l][k];
                    r_ovf[l][k+1]  <= (r_drem[l][k] >= (r_dd[k] << QW));
                    r_neg[l][k+1]  <= r_neg[l][k];
                end
            end else begin : g_bit
                logic [CW-1:0] trial;
                logic          ge;
                assign trial = r_dd[k] << (QW - k);
                assign ge    = (r_drem[l][k] >= trial);
                always_ff @(posedge i_clk) begin
                    r_drem[l][k+1] <= ge ? (r_drem[l][k] - trial) : r_drem[l][k];
                    r_q[l][k+1]    <= {r_q[l][k][QW-2:0], ge};
                    r_ovf[l][k+1]  <= r_ovf[l][k];
                    r_neg[l][k+1]  <= r_neg[l][k];
                end
            end
        end
    end

    for (genvar k = 0; k < DS; k++) begin : g_dctl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dd[k+1]   <= r_dd[k];
            r_half[k+1] <= r_half[k];
            r_hs[k+1]   <= r_hs[k];
            r_bad[k+1]  <= r_bad[k];
        end
    end

    // saturate and place the components
    logic signed [ELEM_W-1:0] lane_val [0:2];
    logic signed [ELEM_W-1:0] half_val;
    t_quat                    n_quat;
    logic                     r_done;
    t_quat                    r_quat;

    for (genvar l = 0; l < 3; l++) begin : g_sat
        always_comb begin
            if (r_neg[l][DS]) begin
                if (r_ovf[l][DS] || (r_q[l][DS] > QW'(32768))) begin
                    lane_val[l] = -16'sd32768;
                end else begin
                    lane_val[l] = ELEM_W'(-r_q[l][DS]);
                end
            end else begin
                if (r_ovf[l][DS] || (r_q[l][DS] > QW'(32767))) begin
                    lane_val[l] = 16'sd32767;
                end else begin
                    lane_val[l] = ELEM_W'(r_q[l][DS]);
                end
            end
        end
    end

    always_comb begin
        if (r_half[DS] > (RW-1)'(32767)) begin
            half_val = 16'sd32767;
        end else begin
            half_val = ELEM_W'(r_half[DS]);
        end
        case (r_hs[DS])
            SLOT_SCALAR: begin
                n_quat.quat_scalar = half_val;
                n_quat.quat_x      = lane_val[0];
                n_quat.quat_y      = lane_val[1];
                n_quat.quat_z      = lane_val[2];
            end
            SLOT_X: begin
                n_quat.quat_scalar = lane_val[0];
                n_quat.quat_x      = half_val;
                n_quat.quat_y      = lane_val[1];
                n_quat.quat_z      = lane_val[2];
            end
            SLOT_Y: begin
                n_quat.quat_scalar = lane_val[0];
                n_quat.quat_x      = lane_val[1];
                n_quat.quat_y      = half_val;
                n_quat.quat_z      = lane_val[2];
            end
            default: begin
                n_quat.quat_scalar = lane_val[0];
                n_quat.quat_x      = lane_val[1];
                n_quat.quat_y      = lane_val[2];
                n_quat.quat_z      = half_val;
            end
        endcase
        n_quat.bad_matrix = r_bad[DS];
        if (r_bad[DS]) begin
            n_quat.quat_scalar = '0;
            n_quat.quat_x      = '0;
            n_quat.quat_y      = '0;
            n_quat.quat_z      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_dv[DS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_quat <= n_quat;
    end

    assign o_done = r_done;
    assign o_quat = r_quat;

endmodule

/* sv/dcm_to_quaternion.sv */
// ----------------------------------------------------------------------------
// dcm_to_quaternion
// rotation matrix (Q2.14) to quaternion converter, while busy is low one request per cycle
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload     direction
//  --------  -----------------  ----------  ---------
//  request   start / busy       i_matrix    in
//  result    o_done (strobe)    o_quat      out
//
//  a request is taken at any clock edge with start high and busy low
//  one request per cycle sustained while busy is low; a request passes in turn
//  through the front register, the queue, the square root pipeline, the divider
//  pipeline with its overflow check, and the output register
//  synchronous active-low reset clears all valid bits, no clearing pass
//  results cannot be held off; busy rises only if the queue is full
//
module dcm_to_quaternion import dtq_pkg::*; #(
    parameter int FRACTION_BITS = 14
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_matrix i_matrix,
    output logic    o_done,
    output t_quat   o_quat
);

    // front to queue
    logic       f_valid;
    t_job       f_job;
    // queue to back
    logic       q_full;
    logic       q_valid;
    t_job       q_job;
    logic [1:0] q_count;

    // classification: branch, pivot, argument and numerators
    dtq_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_matrix (i_matrix),
        .i_q_full (q_full),
        .busy     (busy),
        .o_valid  (f_valid),
        .o_job    (f_job)
    );

    // short queue decoupling front and back
    dtq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_job   (f_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_count (q_count)
    );

    // arithmetic: square root, dividers, saturation and slot placement
    dtq_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_done  (o_done),
        .o_quat  (o_quat)
    );

    // a bad matrix always comes out as all zero parts
    a_bad_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_quat.bad_matrix) |-> (o_quat.quat_scalar == '0 &&
        o_quat.quat_x == '0 && o_quat.quat_y == '0 && o_quat.quat_z == '0))
        else $error("bad matrix result not zeroed");

    // queue never holds more than its two entries
    a_queue_depth : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count != 2'd3)
        else $error("queue count out of range");

    // an accepted request lands in the front register
    a_take : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> f_valid)
        else $error("accepted request lost");

    // busy only while the front holds a request
    a_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (f_valid && q_full))
        else $error("busy without a held request");

endmodule
